@@ sv/rcms_pkg.sv @@
`default_nettype none
package rcms_pkg;

	// Field and register widths
	localparam int CFG_DW   = 24;
	localparam int CFG_IW   = 3;
	localparam int SUM_W    = 36;
	localparam int CNT_W    = 21;
	localparam int D2_W     = 18;
	localparam int SCORE_W  = 15;

	// Distance normalization: 255^2 * 3, and the close threshold on d2
	localparam logic [D2_W-1:0] DIST_DEN = 18'd195075;
	localparam logic [D2_W-1:0] CLOSE_D2 = 18'd4389;

	// Register reset values
	localparam logic [10:0] RST_FRAME_W = 11'd1024;
	localparam logic [10:0] RST_FRAME_H = 11'd1024;
	localparam logic [23:0] RST_FG_RGB  = 24'h79ADA6;
	localparam logic [23:0] RST_BG_RGB  = 24'h073369;

	// Register indexes
	typedef enum logic [CFG_IW-1:0] {
		CFG_FRAME_WIDTH  = 3'd0,
		CFG_FRAME_HEIGHT = 3'd1,
		CFG_ROI_LEFT     = 3'd2,
		CFG_ROI_TOP      = 3'd3,
		CFG_ROI_WIDTH    = 3'd4,
		CFG_ROI_HEIGHT   = 3'd5,
		CFG_FG_TARGET    = 3'd6,
		CFG_BG_TARGET    = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} in_item_t;

	typedef struct packed {
		logic [SCORE_W-1:0] frame_score;
		logic               roi_empty;
	} out_item_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic d2;
		logic sq_init;
		logic sq_step;
		logic score;
		logic accum;
		logic fin_init;
		logic num_init;
		logic den_init;
		logic mul_step;
		logic num_save;
		logic den_save;
		logic round;
		logic qdiv_step;
		logic radd;
		logic out_load;
		logic region;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic frame_end;
		logic roi_empty;
		logic cnt_zero;
	} sts_t;

endpackage
`default_nettype wire

@@ sv/roi_color_match_scorer.sv @@
// Pixels run one at a time: ready returns after d2, 17 square-root steps, score and
// accumulate have run on an accepted pixel; no new pixel is taken before then.
// After the last pixel of a frame, each region ratio runs 21-step products and a 64-step
// divide; a region with no pixels skips both. An undefined rectangle skips the ratio phase.
// Reset: arst_n clears position, accumulators and control, registers to defaults.
`default_nettype none
module roi_color_match_scorer #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [rcms_pkg::CFG_IW-1:0] cfg_index,
	input  wire logic [rcms_pkg::CFG_DW-1:0] cfg_wdata,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire rcms_pkg::in_item_t          in_data,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output rcms_pkg::out_item_t              out_data
);
	import rcms_pkg::*;

	cmd_t cmd;
	sts_t sts;

	rcms_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rcms_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

@@ sv/rcms_dp.sv @@
`default_nettype none
module rcms_dp #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [rcms_pkg::CFG_IW-1:0] cfg_index,
	input  wire logic [rcms_pkg::CFG_DW-1:0] cfg_wdata,
	input  wire rcms_pkg::in_item_t          in_data,
	input  wire rcms_pkg::cmd_t              cmd,
	output rcms_pkg::sts_t                   sts,
	output rcms_pkg::out_item_t              out_data
);
	import rcms_pkg::*;

	localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int PW  = 13;
	localparam int DEN_W = 50;

	// Configuration registers
	logic [10:0] fw_q, fh_q, rw_q, rh_q;
	logic [9:0]  left_q, top_q;
	logic [23:0] fg_q, bg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q   <= RST_FRAME_W;
			fh_q   <= RST_FRAME_H;
			left_q <= '0;
			top_q  <= '0;
			rw_q   <= '0;
			rh_q   <= '0;
			fg_q   <= RST_FG_RGB;
			bg_q   <= RST_BG_RGB;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_FRAME_WIDTH:  fw_q   <= cfg_wdata[10:0];
				CFG_FRAME_HEIGHT: fh_q   <= cfg_wdata[10:0];
				CFG_ROI_LEFT:     left_q <= cfg_wdata[9:0];
				CFG_ROI_TOP:      top_q  <= cfg_wdata[9:0];
				CFG_ROI_WIDTH:    rw_q   <= cfg_wdata[10:0];
				CFG_ROI_HEIGHT:   rh_q   <= cfg_wdata[10:0];
				CFG_FG_TARGET:    fg_q   <= cfg_wdata;
				CFG_BG_TARGET:    bg_q   <= cfg_wdata;
				default:          ;
			endcase
		end
	end

	// Effective frame size, clamped to 1..MAX
	logic [PW-1:0] w_c, h_c, fw_ext, fh_ext;
	always_comb begin
		fw_ext = PW'(fw_q);
		fh_ext = PW'(fh_q);
		if (fw_q == '0)                 w_c = PW'(1);
		else if (fw_ext > PW'(MAX_WIDTH)) w_c = PW'(MAX_WIDTH);
		else                            w_c = fw_ext;
		if (fh_q == '0)                  h_c = PW'(1);
		else if (fh_ext > PW'(MAX_HEIGHT)) h_c = PW'(MAX_HEIGHT);
		else                             h_c = fh_ext;
	end

	// Raster position and region test
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          inside_c, last_col, last_row;
	logic [23:0]   tgt_c;

	assign inside_c = (PW'(col_q) >= PW'(left_q)) &&
	                  (PW'(col_q) < PW'(left_q) + PW'(rw_q)) &&
	                  (PW'(row_q) >= PW'(top_q)) &&
	                  (PW'(row_q) < PW'(top_q) + PW'(rh_q));
	assign last_col = (PW'(col_q) + PW'(1)) >= w_c;
	assign last_row = (PW'(row_q) + PW'(1)) >= h_c;
	assign tgt_c    = inside_c ? fg_q : bg_q;

	function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
		abs_diff = (a > b) ? (a - b) : (b - a);
	endfunction

	logic [7:0]      dr_q, dg_q, db_q;
	logic            inside_q, frame_end_q;
	logic [D2_W-1:0] d2_q;
	logic [1:0]      src_q;
	logic [37:0]     srem_q;
	logic [35:0]     dt_q;
	logic [16:0]     root_q;
	logic [15:0]     sq_q;

	// Root of d2 * 2^32 / DIST_DEN: largest t with t^2 * DIST_DEN <= d2 * 2^32.
	// The remainder is kept scaled by DIST_DEN and dt_q holds DIST_DEN * root.
	logic [37:0] srem_n, trial;
	logic        take;
	logic [15:0] score_c;
	assign srem_n  = {srem_q[35:0], src_q};
	assign trial   = {dt_q, 2'b00} + 38'(DIST_DEN);
	assign take    = srem_n >= trial;
	assign score_c = (root_q == '0) ? 16'hFFFF : 16'(17'h10000 - root_q);

	// Per-pixel datapath
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			inside_q    <= inside_c;
			frame_end_q <= last_col && last_row;
			dr_q        <= abs_diff(in_data.red,   tgt_c[23:16]);
			dg_q        <= abs_diff(in_data.green, tgt_c[15:8]);
			db_q        <= abs_diff(in_data.blue,  tgt_c[7:0]);
		end
		if (cmd.d2)
			d2_q <= D2_W'(16'(dr_q) * 16'(dr_q)) + D2_W'(16'(dg_q) * 16'(dg_q)) +
			        D2_W'(16'(db_q) * 16'(db_q));
		// Two radicand bits a step: d2[1:0] first, then the zero fraction bits
		if (cmd.sq_init) begin
			src_q  <= d2_q[1:0];
			srem_q <= 38'(d2_q[D2_W-1:2]);
			dt_q   <= '0;
			root_q <= '0;
		end
		if (cmd.sq_step) begin
			src_q <= 2'b00;
			if (take) begin
				srem_q <= srem_n - trial;
				dt_q   <= {dt_q[34:0], 1'b0} + 36'(DIST_DEN);
				root_q <= {root_q[15:0], 1'b1};
			end else begin
				srem_q <= srem_n;
				dt_q   <= {dt_q[34:0], 1'b0};
				root_q <= {root_q[15:0], 1'b0};
			end
		end
		if (cmd.score)
			sq_q <= 16'((32'(score_c) * 32'(score_c)) >> 16);
	end

	// Raster position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.load) begin
			if (!last_col) begin
				col_q <= col_q + CW'(1);
			end else if (!last_row) begin
				col_q <= '0;
				row_q <= row_q + RW'(1);
			end else begin
				col_q <= '0;
				row_q <= '0;
			end
		end
	end

	// Region accumulators
	logic [SUM_W-1:0] fg_sum_q, bg_sum_q;
	logic [CNT_W-1:0] fg_cnt_q, bg_cnt_q, fg_close_q, bg_close_q;
	logic             close_c;
	assign close_c = d2_q <= CLOSE_D2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_sum_q   <= '0;
			bg_sum_q   <= '0;
			fg_cnt_q   <= '0;
			bg_cnt_q   <= '0;
			fg_close_q <= '0;
			bg_close_q <= '0;
		end else if (cmd.out_load) begin
			fg_sum_q   <= '0;
			bg_sum_q   <= '0;
			fg_cnt_q   <= '0;
			bg_cnt_q   <= '0;
			fg_close_q <= '0;
			bg_close_q <= '0;
		end else if (cmd.accum) begin
			if (inside_q) begin
				fg_sum_q <= fg_sum_q + SUM_W'(sq_q);
				fg_cnt_q <= fg_cnt_q + CNT_W'(1);
				if (close_c) fg_close_q <= fg_close_q + CNT_W'(1);
			end else begin
				bg_sum_q <= bg_sum_q + SUM_W'(sq_q);
				bg_cnt_q <= bg_cnt_q + CNT_W'(1);
				if (close_c) bg_close_q <= bg_close_q + CNT_W'(1);
			end
		end
	end

	// Frame result: shift-add products, then restoring division
	logic [SUM_W-1:0] sel_sum;
	logic [CNT_W-1:0] sel_cnt, sel_close;
	logic [63:0]      ma_q, acc_q, num_q;
	logic [CNT_W-1:0] mb_q;
	logic [DEN_W-1:0] den_q, frem_q;
	logic [SCORE_W-1:0] total_q;
	logic [DEN_W:0]   fr2;
	logic             fr_ge;
	logic             roi_empty_c;

	assign sel_sum   = cmd.region ? bg_sum_q   : fg_sum_q;
	assign sel_cnt   = cmd.region ? bg_cnt_q   : fg_cnt_q;
	assign sel_close = cmd.region ? bg_close_q : fg_close_q;
	assign fr2       = {frem_q, num_q[63]};
	assign fr_ge     = fr2 >= (DEN_W+1)'(den_q);
	assign roi_empty_c = (rw_q == '0) || (rh_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.num_init) begin
			// 50 * sum = 32s + 16s + 2s
			ma_q  <= (64'(sel_sum) << 5) + (64'(sel_sum) << 4) + (64'(sel_sum) << 1);
			mb_q  <= sel_close;
			acc_q <= '0;
		end
		if (cmd.den_init) begin
			ma_q  <= 64'(sel_cnt) << 8;
			mb_q  <= sel_cnt;
			acc_q <= '0;
		end
		if (cmd.mul_step) begin
			if (mb_q[0]) acc_q <= acc_q + ma_q;
			ma_q <= ma_q << 1;
			mb_q <= mb_q >> 1;
		end
		if (cmd.num_save) num_q <= acc_q;
		if (cmd.den_save) den_q <= acc_q[DEN_W-1:0];
		if (cmd.round) begin
			num_q  <= num_q + 64'(den_q >> 1);
			frem_q <= '0;
		end
		if (cmd.qdiv_step) begin
			num_q  <= {num_q[62:0], fr_ge};
			frem_q <= fr_ge ? DEN_W'(fr2 - (DEN_W+1)'(den_q)) : fr2[DEN_W-1:0];
		end
		if (cmd.fin_init) total_q <= '0;
		if (cmd.radd && !sts.cnt_zero) total_q <= total_q + num_q[SCORE_W-1:0];
		if (cmd.out_load) begin
			out_data.frame_score <= roi_empty_c ? '0 : total_q;
			out_data.roi_empty   <= roi_empty_c;
		end
	end

	assign sts.frame_end = frame_end_q;
	assign sts.roi_empty = roi_empty_c;
	assign sts.cnt_zero  = sel_cnt == '0;

endmodule
`default_nettype wire

@@ sv/rcms_ctrl.sv @@
`default_nettype none
module rcms_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire logic           out_ready,
	input  wire rcms_pkg::sts_t sts,
	output rcms_pkg::cmd_t      cmd
);
	import rcms_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_D2, S_SQ_INIT, S_SQRT, S_SCORE, S_ACC,
		S_FIN_INIT, S_REG, S_NUM_INIT, S_NUM_MUL, S_NUM_SAVE, S_DEN_INIT,
		S_DEN_MUL, S_DEN_SAVE, S_ROUND, S_QDIV, S_RADD, S_OUT
	} state_t;

	// Step counts minus one
	localparam logic [5:0] SQRT_LAST = 6'd16;
	localparam logic [5:0] MUL_LAST  = 6'd20;
	localparam logic [5:0] QDIV_LAST = 6'd63;

	state_t     state_q;
	logic [5:0] cnt_q;
	logic       region_q;
	logic       out_valid_q;
	logic       out_free;

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	// Command decode
	always_comb begin
		cmd           = '0;
		cmd.region    = region_q;
		cmd.load      = in_valid && in_ready;
		cmd.d2        = state_q == S_D2;
		cmd.sq_init   = state_q == S_SQ_INIT;
		cmd.sq_step   = state_q == S_SQRT;
		cmd.score     = state_q == S_SCORE;
		cmd.accum     = state_q == S_ACC;
		cmd.fin_init  = state_q == S_FIN_INIT;
		cmd.num_init  = state_q == S_NUM_INIT;
		cmd.den_init  = state_q == S_DEN_INIT;
		cmd.mul_step  = (state_q == S_NUM_MUL) || (state_q == S_DEN_MUL);
		cmd.num_save  = state_q == S_NUM_SAVE;
		cmd.den_save  = state_q == S_DEN_SAVE;
		cmd.round     = state_q == S_ROUND;
		cmd.qdiv_step = state_q == S_QDIV;
		cmd.radd      = state_q == S_RADD;
		cmd.out_load  = (state_q == S_OUT) && out_free;
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			region_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// Result register: load wins over a drain in the same cycle
			if (cmd.out_load)   out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE:     if (in_valid) state_q <= S_D2;
				S_D2:       state_q <= S_SQ_INIT;
				S_SQ_INIT: begin
					state_q <= S_SQRT;
					cnt_q   <= SQRT_LAST;
				end
				S_SQRT: begin
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == '0) state_q <= S_SCORE;
				end
				S_SCORE:    state_q <= S_ACC;
				S_ACC: begin
					if (!sts.frame_end)    state_q <= S_IDLE;
					else if (sts.roi_empty) state_q <= S_OUT;
					else                   state_q <= S_FIN_INIT;
				end
				S_FIN_INIT: begin
					region_q <= 1'b0;
					state_q  <= S_REG;
				end
				S_REG:      state_q <= sts.cnt_zero ? S_RADD : S_NUM_INIT;
				S_NUM_INIT: begin
					state_q <= S_NUM_MUL;
					cnt_q   <= MUL_LAST;
				end
				S_NUM_MUL: begin
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == '0) state_q <= S_NUM_SAVE;
				end
				S_NUM_SAVE: state_q <= S_DEN_INIT;
				S_DEN_INIT: begin
					state_q <= S_DEN_MUL;
					cnt_q   <= MUL_LAST;
				end
				S_DEN_MUL: begin
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == '0) state_q <= S_DEN_SAVE;
				end
				S_DEN_SAVE: state_q <= S_ROUND;
				S_ROUND: begin
					state_q <= S_QDIV;
					cnt_q   <= QDIV_LAST;
				end
				S_QDIV: begin
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == '0) state_q <= S_RADD;
				end
				S_RADD: begin
					if (region_q) begin
						state_q <= S_OUT;
					end else begin
						region_q <= 1'b1;
						state_q  <= S_REG;
					end
				end
				S_OUT:      if (out_free) state_q <= S_IDLE;
				default:    state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ sv/rcms_chk.sv @@
`default_nettype none
module rcms_chk (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_ready,
	input wire rcms_pkg::in_item_t  in_data,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire rcms_pkg::out_item_t out_data
);
	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// An undefined rectangle forces a zero score
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.roi_empty |-> out_data.frame_score == '0)
		else $error("empty rectangle with nonzero score");

	// One item at a time: busy right after an accepted item
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while busy");

	// A result never appears in the cycle after an item is taken
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result too early");

endmodule

bind roi_color_match_scorer rcms_chk u_rcms_chk (.*);
`default_nettype wire
